FILE: hdl/ttf_pkg.sv
// Package for the triangle tangent frame block: widths and shared constants.
`default_nettype none
package ttf_pkg;
	localparam int PosW   = 32;
	localparam int TexW   = 16;
	localparam int OutW   = 16;
	localparam int NormW  = 30;
	localparam int OneQ14 = 16384;
	// edge difference 33 b, uv delta 17 b, product 50 b, difference 51 b
	localparam int EdgeW  = PosW + 1;
	localparam int DltW   = TexW + 1;
	localparam int CompW  = EdgeW + DltW + 1;
	localparam int InW    = 3 * PosW + 2 * TexW;
	localparam int OutDW  = 6 * OutW;
endpackage
`default_nettype wire

FILE: hdl/ttf_divsqrt.sv
// Shared iterative unit: one bit per cycle of an integer square root or a divide.
`default_nettype none
module ttf_divsqrt (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic        is_sqrt,
	input  wire logic [63:0] num,
	input  wire logic [63:0] den,
	output logic             done,
	output logic [63:0]      res
);
	import ttf_pkg::*;

	logic [63:0] rem_q, bit_q, res_q, den_q, num_q;
	logic        busy_q, sqrt_q;
	logic [5:0]  cnt_q;
	logic [64:0] trial;
	logic [63:0] rem_sh;

	assign rem_sh = {rem_q[62:0], num_q[63]};
	assign trial  = sqrt_q ? {1'b0, rem_q} - {1'b0, res_q + bit_q}
	                       : {1'b0, rem_sh} - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				sqrt_q <= is_sqrt;
				cnt_q  <= 6'd63;
				rem_q  <= is_sqrt ? num : 64'd0;
				num_q  <= num;
				den_q  <= den;
				bit_q  <= 64'h4000_0000_0000_0000;
				res_q  <= 64'd0;
			end else if (busy_q) begin
				if (sqrt_q) begin
					if (!trial[64]) begin
						rem_q <= trial[63:0];
						res_q <= (res_q >> 1) + bit_q;
					end else begin
						res_q <= res_q >> 1;
					end
					bit_q <= bit_q >> 2;
					if (bit_q[0] || bit_q == 64'd0) begin
						busy_q <= 1'b0;
						done   <= 1'b1;
					end
				end else begin
					num_q <= {num_q[62:0], 1'b0};
					if (!trial[64]) begin
						rem_q <= trial[63:0];
						res_q <= {res_q[62:0], 1'b1};
					end else begin
						rem_q <= rem_sh;
						res_q <= {res_q[62:0], 1'b0};
					end
					cnt_q <= cnt_q - 6'd1;
					if (cnt_q == 6'd0) begin
						busy_q <= 1'b0;
						done   <= 1'b1;
					end
				end
			end
		end
	end

	always_comb begin
		res = res_q;
		if (sqrt_q && !trial[64])
			res = res_q;
	end
endmodule
`default_nettype wire

FILE: hdl/triangle_tangent_frame.sv
// Top level of the triangle tangent frame block: corner holding, sequencer and output.
`default_nettype none
// Corners arrive one item each; the first two of a triangle are held. On
// the third corner a small sequencer forms the edges and UV deltas, then
// computes the six tangent and bitangent components and the determinant
// with one shared 33x17 multiplier (two products per component). Each
// vector is then normalized: a scan finds the largest magnitude, one shared
// iterative unit takes the square root of the sum of squares and then
// three divides; the cost of a third corner is set by the bit-serial
// root/divide unit. The same frame then leaves as three items, tlast on
// the third; the block accepts no corner until all three are taken. Zero
// determinant or a zero vector yields zeros with the degenerate flag set.
module triangle_tangent_frame (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        s_tvalid,
	output logic                             s_tready,
	// pos_x, pos_y, pos_z, tex_u, tex_v
	input  wire logic [ttf_pkg::InW-1:0]     s_tdata,
	output logic                             m_tvalid,
	input  wire logic                        m_tready,
	// tangent_x/y/z, bitangent_x/y/z
	output logic [ttf_pkg::OutDW-1:0]        m_tdata,
	// degenerate
	output logic                             m_tuser,
	output logic                             m_tlast
);
	import ttf_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE, ST_EDGE, ST_MUL, ST_SCAN, ST_SQ, ST_SQRT, ST_DIV, ST_NEXT, ST_OUT
	} state_t;

	state_t state_q;
	logic [1:0] corner_q;
	logic signed [PosW-1:0] hpos_q [6];
	logic signed [TexW-1:0] htex_q [4];
	logic signed [PosW-1:0] p2_q [3];
	logic signed [TexW-1:0] t2_q [2];
	logic signed [EdgeW-1:0] e1_q [3], e2_q [3];
	logic signed [DltW-1:0] x1_q, x2_q, y1_q, y2_q;
	logic signed [CompW-1:0] comp_q [6];
	logic signed [CompW-1:0] det_q, acc_q;
	logic [3:0] step_q;
	logic       vec_q;
	logic [1:0] idx_q;
	logic [63:0] mag_q [3];
	logic [63:0] mx_q, sum_q, len_q;
	logic [6:0]  nbits_q;
	logic [OutW-1:0] res_q [6];
	logic        bad_q, started_q;
	logic [1:0]  outc_q;

	// shared multiplier
	logic signed [EdgeW-1:0] ma;
	logic signed [DltW-1:0]  mb;
	logic signed [CompW-1:0] prod;
	assign prod = CompW'(ma * mb);

	logic        du_start, du_sqrt, du_done;
	logic [63:0] du_num, du_den, du_res;
	ttf_divsqrt u_du (.clk, .arst_n, .start(du_start), .is_sqrt(du_sqrt),
		.num(du_num), .den(du_den), .done(du_done), .res(du_res));

	// step_q 0..11: component k = step>>1, product of pair; 12,13: det
	logic [2:0] comp_i;
	assign comp_i = 3'(step_q >> 1);
	always_comb begin
		ma = '0;
		mb = '0;
		if (step_q >= 4'd12) begin
			ma = EdgeW'(step_q[0] ? x2_q : x1_q);
			mb = step_q[0] ? y1_q : y2_q;
		end else if (comp_i < 3'd3) begin
			ma = step_q[0] ? e2_q[comp_i[1:0]] : e1_q[comp_i[1:0]];
			mb = step_q[0] ? y1_q : y2_q;
		end else begin
			ma = step_q[0] ? e1_q[2'(comp_i - 3'd3)] : e2_q[2'(comp_i - 3'd3)];
			mb = step_q[0] ? x2_q : x1_q;
		end
	end

	logic signed [CompW-1:0] cur_c;
	logic [2:0] cidx;
	assign cidx = vec_q ? 3'(idx_q) + 3'd3 : 3'(idx_q);
	assign cur_c = comp_q[cidx];
	logic [63:0] cur_m;
	assign cur_m = cur_c[CompW-1] ? 64'(-cur_c) : 64'(cur_c);
	logic [63:0] sc_m;
	always_comb begin
		if (nbits_q > 7'(NormW)) sc_m = mag_q[idx_q] >> (nbits_q - 7'(NormW));
		else sc_m = mag_q[idx_q] << (7'(NormW) - nbits_q);
	end

	// scaled magnitude fits in NormW+1 bits, so its square is a narrow product
	logic [NormW:0]      sc_n;
	logic [2*NormW+1:0]  sc_sq;
	assign sc_n  = sc_m[NormW:0];
	assign sc_sq = sc_n * sc_n;

	// bit length of the largest magnitude
	logic [6:0] mx_len;
	always_comb begin
		mx_len = '0;
		for (int b = 0; b < 64; b++)
			if (mx_q[b]) mx_len = 7'(b + 1);
	end

	assign du_sqrt  = (state_q == ST_SQ) && idx_q == 2'd3;
	assign du_start = ((state_q == ST_SQ && idx_q == 2'd3) ||
	                   (state_q == ST_DIV && !started_q));
	assign du_num = du_sqrt ? sum_q : ((mag_q[idx_q] << 15) + len_q);
	assign du_den = len_q << 1;

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = (state_q == ST_OUT);
	assign m_tdata  = {res_q[5], res_q[4], res_q[3], res_q[2], res_q[1], res_q[0]};
	assign m_tuser  = bad_q;
	assign m_tlast  = (outc_q == 2'd2);

	logic signed [OutW-1:0] qv;
	logic ng;
	assign ng = cur_c[CompW-1] ^ det_q[CompW-1];
	assign qv = ng ? -OutW'(du_res) : OutW'(du_res);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			corner_q  <= 2'd0;
			outc_q    <= 2'd0;
			started_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: if (s_tvalid) begin
					if (corner_q < 2'd2) begin
						for (int i = 0; i < 3; i++)
							hpos_q[3'(corner_q[0] ? 3 + i : i)] <= s_tdata[i*PosW +: PosW];
						htex_q[{corner_q[0], 1'b0}] <= s_tdata[3*PosW +: TexW];
						htex_q[{corner_q[0], 1'b1}] <= s_tdata[3*PosW+TexW +: TexW];
						corner_q <= corner_q + 2'd1;
					end else begin
						for (int i = 0; i < 3; i++) p2_q[i] <= s_tdata[i*PosW +: PosW];
						t2_q[0] <= s_tdata[3*PosW +: TexW];
						t2_q[1] <= s_tdata[3*PosW+TexW +: TexW];
						corner_q <= 2'd0;
						state_q  <= ST_EDGE;
					end
				end
				ST_EDGE: begin
					for (int i = 0; i < 3; i++) begin
						e1_q[i] <= EdgeW'(hpos_q[3+i]) - EdgeW'(hpos_q[i]);
						e2_q[i] <= EdgeW'(p2_q[i]) - EdgeW'(hpos_q[i]);
					end
					x1_q <= DltW'(htex_q[2]) - DltW'(htex_q[0]);
					x2_q <= DltW'(t2_q[0]) - DltW'(htex_q[0]);
					y1_q <= DltW'(htex_q[3]) - DltW'(htex_q[1]);
					y2_q <= DltW'(t2_q[1]) - DltW'(htex_q[1]);
					step_q  <= 4'd0;
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					if (!step_q[0]) acc_q <= prod;
					else if (step_q == 4'd13) det_q <= acc_q - prod;
					else comp_q[comp_i] <= acc_q - prod;
					step_q <= step_q + 4'd1;
					if (step_q == 4'd13) begin
						vec_q   <= 1'b0;
						idx_q   <= 2'd0;
						mx_q    <= '0;
						bad_q   <= (acc_q == prod);
						state_q <= (acc_q == prod) ? ST_NEXT : ST_SCAN;
					end
				end
				ST_SCAN: begin
					mag_q[idx_q] <= cur_m;
					if (cur_m > mx_q) mx_q <= cur_m;
					if (idx_q == 2'd2) begin
						idx_q   <= 2'd0;
						sum_q   <= '0;
						nbits_q <= '0;
						state_q <= ST_SQ;
					end else begin
						idx_q <= idx_q + 2'd1;
					end
				end
				ST_SQ: begin
					if (mx_q == 64'd0) begin
						bad_q   <= 1'b1;
						state_q <= ST_NEXT;
					end else if (nbits_q == 7'd0) begin
						nbits_q <= mx_len;
						idx_q   <= 2'd0;
					end else if (idx_q != 2'd3) begin
						mag_q[idx_q] <= sc_m;
						sum_q <= sum_q + 64'(sc_sq);
						idx_q <= idx_q + 2'd1;
					end else begin
						state_q <= ST_SQRT;
					end
				end
				ST_SQRT: if (du_done) begin
					len_q     <= du_res;
					idx_q     <= 2'd0;
					started_q <= 1'b0;
					state_q   <= ST_DIV;
				end
				ST_DIV: begin
					if (du_done && started_q) begin
						res_q[cidx] <= qv;
						started_q   <= 1'b0;
						if (idx_q == 2'd2) begin
							if (!vec_q) begin
								vec_q   <= 1'b1;
								idx_q   <= 2'd0;
								mx_q    <= '0;
								state_q <= ST_SCAN;
							end else begin
								state_q <= ST_OUT;
							end
						end else begin
							idx_q <= idx_q + 2'd1;
						end
					end else begin
						started_q <= 1'b1;
					end
				end
				ST_NEXT: begin
					for (int i = 0; i < 6; i++) res_q[i] <= '0;
					state_q <= ST_OUT;
				end
				ST_OUT: if (m_tready) begin
					if (outc_q == 2'd2) begin
						outc_q  <= 2'd0;
						state_q <= ST_IDLE;
					end else begin
						outc_q <= outc_q + 2'd1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (state_q == ST_OUT && bad_q)
				for (int i = 0; i < 6; i++) res_q[i] <= '0;
		end
	end

	ap_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid)) else $error("ready while results pending");
	ap_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && m_tlast |=> s_tready) else $error("frame end");
	ap_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser && $past(m_tvalid) |-> m_tdata == '0)
		else $error("degenerate frame not zero");
endmodule
`default_nettype wire
